// File: sv/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg: shared types and constants of the S-box lookup unit
// Register indexes, lookup mode codes and the control bundles that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package msl_pkg;

	// Number of lookup memories.
	localparam int NUM_TABLES = 4;

	// Register indexes on the configuration port (byte address / 4).
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_BANK0 = 3'd1;
	localparam logic [2:0] REG_BANK1 = 3'd2;
	localparam logic [2:0] REG_BANK2 = 3'd3;
	localparam logic [2:0] REG_BANK3 = 3'd4;

	// Lookup mode codes.
	localparam logic [2:0] MODE_NIB4  = 3'd0;
	localparam logic [2:0] MODE_NIB6  = 3'd1;
	localparam logic [2:0] MODE_BYTE  = 3'd2;
	localparam logic [2:0] MODE_FOLD  = 3'd3;
	localparam logic [2:0] MODE_WORDS = 3'd4;
	localparam logic [2:0] MODE_SEL9  = 3'd5;

	// Request opcodes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_WRITE  = 1'b1;

	// Configuration register contents.
	typedef struct packed {
		logic [2:0]                 mode;
		logic [NUM_TABLES-1:0][1:0] bank;
	} cfg_t;

	// Control that follows a lookup request through the pipeline.
	typedef struct packed {
		logic       valid;
		logic [2:0] mode;
		logic       sel_hi;
	} lookup_ctrl_t;

endpackage

// File: sv/msl_regs.sv
// ----------------------------------------------------------------------------
// msl_regs: configuration registers
// APB-style register file holding the lookup mode and four bank selects.
// ----------------------------------------------------------------------------
module msl_regs
	import msl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes; addresses beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:  cfg_q.mode    <= pwdata[2:0];
				REG_BANK0: cfg_q.bank[0] <= pwdata[1:0];
				REG_BANK1: cfg_q.bank[1] <= pwdata[1:0];
				REG_BANK2: cfg_q.bank[2] <= pwdata[1:0];
				REG_BANK3: cfg_q.bank[3] <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (reg_idx)
			REG_MODE:  prdata = {29'd0, cfg_q.mode};
			REG_BANK0: prdata = {30'd0, cfg_q.bank[0]};
			REG_BANK1: prdata = {30'd0, cfg_q.bank[1]};
			REG_BANK2: prdata = {30'd0, cfg_q.bank[2]};
			REG_BANK3: prdata = {30'd0, cfg_q.bank[3]};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// File: sv/msl_addr_gen.sv
// ----------------------------------------------------------------------------
// msl_addr_gen: first pipeline stage
// Splits the lookup word into four indices, adds the bank selects, wraps the
// address to the table depth and decodes table writes.
// ----------------------------------------------------------------------------
module msl_addr_gen
	import msl_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req,
	input  logic                               opcode,
	input  logic [31:0]                        lookup_word,
	input  logic [1:0]                         write_table,
	input  logic [9:0]                         write_addr,
	input  logic [31:0]                        write_data,
	input  cfg_t                               cfg,
	output lookup_ctrl_t                       ctrl_s1,
	output logic [NUM_TABLES-1:0][$clog2(TABLE_DEPTH)-1:0] rd_addr_s1,
	output logic [NUM_TABLES-1:0]              wr_en_s1,
	output logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr_s1,
	output logic [31:0]                        wr_data_s1
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [13:0] DEPTH_1 = 14'(TABLE_DEPTH);
	localparam logic [13:0] DEPTH_2 = 14'(2 * TABLE_DEPTH);
	localparam logic [13:0] DEPTH_3 = 14'(3 * TABLE_DEPTH);

	logic [NUM_TABLES-1:0][7:0]  idx;
	logic [NUM_TABLES-1:0][13:0] raw_addr;
	logic [NUM_TABLES-1:0][13:0] wrap_addr;
	logic [NUM_TABLES-1:0]       wr_hit;
	logic                        wr_in_range;
	lookup_ctrl_t                ctrl_d;

	// Index split by mode; undefined modes read address zero.
	always_comb begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			case (cfg.mode)
				MODE_NIB4: idx[i] = {4'd0, lookup_word[4*i +: 4]};
				MODE_NIB6: idx[i] = {2'd0, lookup_word[6*i +: 6]};
				default:   idx[i] = lookup_word[8*i +: 8];
			endcase
			if (cfg.mode > MODE_SEL9) begin
				raw_addr[i] = 14'd0;
			end else begin
				raw_addr[i] = {4'd0, cfg.bank[i], idx[i]};
			end
		end
	end

	// Address wrap modulo the depth; the raw address stays below four depths.
	always_comb begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			if (raw_addr[i] >= DEPTH_3) begin
				wrap_addr[i] = raw_addr[i] - DEPTH_3;
			end else if (raw_addr[i] >= DEPTH_2) begin
				wrap_addr[i] = raw_addr[i] - DEPTH_2;
			end else if (raw_addr[i] >= DEPTH_1) begin
				wrap_addr[i] = raw_addr[i] - DEPTH_1;
			end else begin
				wrap_addr[i] = raw_addr[i];
			end
		end
	end

	// Table write decode; writes past the depth are dropped.
	assign wr_in_range = 14'(write_addr) < DEPTH_1;
	always_comb begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			wr_hit[i] = req && (opcode == OP_WRITE) && wr_in_range &&
				(write_table == 2'(i));
		end
	end

	assign ctrl_d.valid  = req && (opcode == OP_LOOKUP);
	assign ctrl_d.mode   = cfg.mode;
	assign ctrl_d.sel_hi = lookup_word[8];

	// Stage 1 control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1  <= '0;
			wr_en_s1 <= '0;
		end else begin
			ctrl_s1  <= ctrl_d;
			wr_en_s1 <= wr_hit;
		end
	end

	// Stage 1 payload registers.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			rd_addr_s1[i] <= AW'(wrap_addr[i]);
		end
		wr_addr_s1 <= AW'(write_addr);
		wr_data_s1 <= write_data;
	end

endmodule

// File: sv/msl_table_ram.sv
// ----------------------------------------------------------------------------
// msl_table_ram: one lookup memory
// Single write port and one registered read port.
// ----------------------------------------------------------------------------
module msl_table_ram #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [31:0]                    wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output logic [31:0]                    rd_data_s2
);

	logic [31:0] mem [TABLE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

endmodule

// File: sv/msl_combine.sv
// ----------------------------------------------------------------------------
// msl_combine: result assembly stage
// Combines the four words read into the result fields as the mode says and
// drives the registered result strobe.
// ----------------------------------------------------------------------------
module msl_combine
	import msl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  lookup_ctrl_t                 ctrl_s1,
	input  logic [NUM_TABLES-1:0][31:0]  rd_data_s2,
	output logic                         result_valid,
	output logic [31:0]                  result_0,
	output logic [31:0]                  result_1,
	output logic [31:0]                  result_2,
	output logic [31:0]                  result_3
);

	lookup_ctrl_t               ctrl_s2;
	logic [NUM_TABLES-1:0][7:0] fold;
	logic [NUM_TABLES-1:0][31:0] res_d;
	logic                       valid_s3;
	logic [NUM_TABLES-1:0][31:0] res_s3;

	// Control follows the memory read latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	// Byte-XOR fold of each word.
	always_comb begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			fold[i] = rd_data_s2[i][31:24] ^ rd_data_s2[i][23:16] ^
				rd_data_s2[i][15:8] ^ rd_data_s2[i][7:0];
		end
	end

	// Result combination.
	always_comb begin
		res_d = '0;
		case (ctrl_s2.mode)
			MODE_NIB4, MODE_NIB6: begin
				res_d[0] = {16'd0, rd_data_s2[3][3:0], rd_data_s2[2][3:0],
					rd_data_s2[1][3:0], rd_data_s2[0][3:0]};
			end
			MODE_BYTE: begin
				res_d[0] = {rd_data_s2[3][7:0], rd_data_s2[2][7:0],
					rd_data_s2[1][7:0], rd_data_s2[0][7:0]};
			end
			MODE_FOLD: begin
				res_d[0] = {fold[3], fold[2], fold[1], fold[0]};
			end
			MODE_WORDS: begin
				res_d = rd_data_s2;
			end
			MODE_SEL9: begin
				if (ctrl_s2.sel_hi) begin
					res_d[0] = {23'd0, rd_data_s2[0][24:16]};
				end else begin
					res_d[0] = {23'd0, rd_data_s2[0][8:0]};
				end
			end
			default: res_d = '0;
		endcase
	end

	// Output strobe register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctrl_s2.valid;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			res_s3 <= res_d;
		end
	end

	assign result_valid = valid_s3;
	assign result_0     = res_s3[0];
	assign result_1     = res_s3[1];
	assign result_2     = res_s3[2];
	assign result_3     = res_s3[3];

endmodule

// File: sv/multi_mode_sbox_lookup.sv
// A lookup result passes the stage 1 registers, the memory read register and the output register before it shows.
// Throughput: one request per cycle; busy never rises since the result side has no stall.
// Table writes land in the memory in the cycle after they are taken and give no result.
// Reset clears the configuration registers and pipeline valid bits; memories keep contents.
// ----------------------------------------------------------------------------
// multi_mode_sbox_lookup: reconfigurable S-box lookup unit
// Four 32-bit lookup memories read in parallel by a three-stage pipeline:
// address generation, memory read, result assembly.
// ----------------------------------------------------------------------------
module multi_mode_sbox_lookup
	import msl_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [31:0] lookup_word,
	input  logic [1:0]  write_table,
	input  logic [9:0]  write_addr,
	input  logic [31:0] write_data,
	output logic        result_valid,
	output logic [31:0] result_0,
	output logic [31:0] result_1,
	output logic [31:0] result_2,
	output logic [31:0] result_3,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(TABLE_DEPTH);

	cfg_t                             cfg;
	lookup_ctrl_t                     ctrl_s1;
	logic [NUM_TABLES-1:0][AW-1:0]    rd_addr_s1;
	logic [NUM_TABLES-1:0]            wr_en_s1;
	logic [AW-1:0]                    wr_addr_s1;
	logic [31:0]                      wr_data_s1;
	logic [NUM_TABLES-1:0][31:0]      rd_data_s2;

	// The pipeline takes a request every cycle.
	assign busy = 1'b0;

	// Configuration registers.
	msl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: address generation and write decode.
	msl_addr_gen #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_addr_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (start),
		.opcode      (opcode),
		.lookup_word (lookup_word),
		.write_table (write_table),
		.write_addr  (write_addr),
		.write_data  (write_data),
		.cfg         (cfg),
		.ctrl_s1     (ctrl_s1),
		.rd_addr_s1  (rd_addr_s1),
		.wr_en_s1    (wr_en_s1),
		.wr_addr_s1  (wr_addr_s1),
		.wr_data_s1  (wr_data_s1)
	);

	// Stage 2: the four lookup memories.
	for (genvar g = 0; g < NUM_TABLES; g++) begin : g_table
		msl_table_ram #(
			.TABLE_DEPTH (TABLE_DEPTH)
		) u_ram (
			.clk        (clk),
			.wr_en      (wr_en_s1[g]),
			.wr_addr    (wr_addr_s1),
			.wr_data    (wr_data_s1),
			.rd_en      (ctrl_s1.valid),
			.rd_addr    (rd_addr_s1[g]),
			.rd_data_s2 (rd_data_s2[g])
		);
	end

	// Stage 3: result assembly and output register.
	msl_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_s1      (ctrl_s1),
		.rd_data_s2   (rd_data_s2),
		.result_valid (result_valid),
		.result_0     (result_0),
		.result_1     (result_1),
		.result_2     (result_2),
		.result_3     (result_3)
	);

endmodule

// File: bench/multi_mode_sbox_lookup_test.sv
// ----------------------------------------------------------------------------
// multi_mode_sbox_lookup_test: self-checking bench for the S-box lookup unit
// Table writes and lookups go in through the start/busy request port, and the
// mode and bank registers are set over the APB port while the unit is idle.
// A local copy of the four memories and the registers predicts every lookup
// result, and each result strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module multi_mode_sbox_lookup_test;
	import msl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET   = 1550;
	localparam int SETTLE_CYCLES = 5;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;
	localparam int CALM_FIRST    = 600;
	localparam int CALM_LAST     = 900;

	// Modes outside the defined set give all-zero results.
	localparam logic [2:0] MODE_ZERO6 = 3'd6;
	localparam logic [2:0] MODE_ZERO7 = 3'd7;

	typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_PAUSE} step_kind_e;
	typedef enum logic [1:0] {BUS_IDLE, BUS_SETUP, BUS_ACCESS} bus_phase_e;

	typedef struct {
		step_kind_e  kind;
		logic        op;
		logic [31:0] word;
		logic [1:0]  tbl;
		logic [9:0]  waddr;
		logic [31:0] wdata;
		logic [2:0]  reg_idx;
		logic [31:0] reg_val;
	} plan_step_t;

	typedef struct packed {
		logic [31:0] r0;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
	} lookup_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        opcode = OP_LOOKUP;
	logic [31:0] lookup_word = '0;
	logic [1:0]  write_table = '0;
	logic [9:0]  write_addr = '0;
	logic [31:0] write_data = '0;
	logic        result_valid;
	logic [31:0] result_0;
	logic [31:0] result_1;
	logic [31:0] result_2;
	logic [31:0] result_3;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Planned stimulus and the settings it is built against.
	plan_step_t stim_plan[$];
	bit         tbl_written [4][1024];
	logic [2:0] gen_mode = MODE_NIB4;
	logic [1:0] gen_bank [4] = '{default: 2'd0};
	int         n_planned_items = 0;

	// Predicted state of the unit.
	logic [31:0]    sbox_mem [4][1024];
	logic [2:0]     cfg_mode = MODE_NIB4;
	logic [1:0]     cfg_bank [4] = '{default: 2'd0};
	lookup_result_t lookup_expect[$];
	int             n_predicted = 0;
	int             n_checked = 0;
	int             fail_count = 0;

	// Driver bookkeeping.
	bus_phase_e bus_phase = BUS_IDLE;
	plan_step_t next_step;
	int         settle_count = 0;
	int         n_taken = 0;
	bit         plan_drained = 1'b0;
	int         cycle_count = 0;

	multi_mode_sbox_lookup u_top (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Memory address that a lookup word selects in one table.
	function automatic logic [9:0] index_for(logic [31:0] word, logic [2:0] mode,
		logic [1:0] bank, int t);
		logic [7:0] field;
		case (mode)
			MODE_NIB4: field = 8'(word >> (4 * t)) & 8'h0f;
			MODE_NIB6: field = 8'(word >> (6 * t)) & 8'h3f;
			MODE_BYTE, MODE_FOLD, MODE_WORDS, MODE_SEL9: field = 8'(word >> (8 * t));
			default: return 10'd0;
		endcase
		return {bank, field};
	endfunction

	function automatic logic [7:0] byte_fold(logic [31:0] w);
		return w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
	endfunction

	// ------------------------------------------------------------------
	// Plan building
	// ------------------------------------------------------------------
	task automatic plan_write(logic [1:0] t, logic [9:0] a, logic [31:0] d);
		plan_step_t s;
		s = '{kind: STEP_REQ, op: OP_WRITE, word: $urandom, tbl: t, waddr: a, wdata: d,
			reg_idx: REG_MODE, reg_val: '0};
		stim_plan.insert(stim_plan.size(), s);
		tbl_written[t][a] = 1'b1;
		n_planned_items++;
	endtask

	// A lookup is preceded by writes to any entry it would read unwritten.
	task automatic plan_lookup(logic [31:0] word);
		plan_step_t s;
		logic [9:0] a;
		for (int t = 0; t < 4; t++) begin
			a = index_for(word, gen_mode, gen_bank[t], t);
			if (!tbl_written[t][a])
				plan_write(2'(t), a, $urandom);
		end
		s = '{kind: STEP_REQ, op: OP_LOOKUP, word: word, tbl: 2'($urandom),
			waddr: 10'($urandom), wdata: $urandom, reg_idx: REG_MODE, reg_val: '0};
		stim_plan.insert(stim_plan.size(), s);
		n_planned_items++;
	endtask

	task automatic plan_pause();
		plan_step_t s;
		s = '{kind: STEP_PAUSE, op: OP_LOOKUP, word: '0, tbl: '0, waddr: '0, wdata: '0,
			reg_idx: REG_MODE, reg_val: '0};
		stim_plan.insert(stim_plan.size(), s);
	endtask

	task automatic plan_reg(logic [2:0] idx, logic [31:0] value);
		plan_step_t s;
		s = '{kind: STEP_CFG, op: OP_LOOKUP, word: '0, tbl: '0, waddr: '0, wdata: '0,
			reg_idx: idx, reg_val: value};
		stim_plan.insert(stim_plan.size(), s);
	endtask

	// Drain the unit, then write all five registers.
	task automatic plan_phase(logic [2:0] mode, logic [1:0] b0, logic [1:0] b1,
		logic [1:0] b2, logic [1:0] b3);
		plan_pause();
		plan_reg(REG_MODE, {29'd0, mode});
		plan_reg(REG_BANK0, {30'd0, b0});
		plan_reg(REG_BANK1, {30'd0, b1});
		plan_reg(REG_BANK2, {30'd0, b2});
		plan_reg(REG_BANK3, {30'd0, b3});
		gen_mode = mode;
		gen_bank = '{b0, b1, b2, b3};
	endtask

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	task automatic predict_request();
		logic [31:0]    w [4];
		lookup_result_t res;
		if (opcode == OP_WRITE) begin
			sbox_mem[write_table][write_addr] = write_data;
			return;
		end
		for (int t = 0; t < 4; t++)
			w[t] = sbox_mem[t][index_for(lookup_word, cfg_mode, cfg_bank[t], t)];
		res = '0;
		case (cfg_mode)
			MODE_NIB4, MODE_NIB6: begin
				res.r0 = {16'd0, w[3][3:0], w[2][3:0], w[1][3:0], w[0][3:0]};
			end
			MODE_BYTE: begin
				res.r0 = {w[3][7:0], w[2][7:0], w[1][7:0], w[0][7:0]};
			end
			MODE_FOLD: begin
				res.r0 = {byte_fold(w[3]), byte_fold(w[2]), byte_fold(w[1]), byte_fold(w[0])};
			end
			MODE_WORDS: begin
				res = {w[0], w[1], w[2], w[3]};
			end
			MODE_SEL9: begin
				// Bit 8 of the word picks bits 24:16 or the lower nine bits of table zero.
				res.r0 = lookup_word[8] ? {23'd0, w[0][24:16]} : {23'd0, w[0][8:0]};
			end
			default: ;
		endcase
		lookup_expect.insert(lookup_expect.size(), res);
		n_predicted++;
	endtask

	task automatic apply_register(logic [2:0] idx, logic [31:0] value);
		case (idx)
			REG_MODE:  cfg_mode = value[2:0];
			REG_BANK0: cfg_bank[0] = value[1:0];
			REG_BANK1: cfg_bank[1] = value[1:0];
			REG_BANK2: cfg_bank[2] = value[1:0];
			REG_BANK3: cfg_bank[3] = value[1:0];
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: request port and register port
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			bus_phase <= BUS_IDLE;
			settle_count <= 0;
		end else begin
			// Retire the request taken at this edge.
			if (start && !busy) begin
				predict_request();
				n_taken++;
			end
			if (bus_phase == BUS_SETUP) begin
				penable <= 1'b1;
				bus_phase <= BUS_ACCESS;
			end else if (bus_phase == BUS_ACCESS) begin
				if (pready) begin
					apply_register(paddr[4:2], pwdata);
					psel <= 1'b0;
					penable <= 1'b0;
					pwrite <= 1'b0;
					bus_phase <= BUS_IDLE;
				end
			end else if (!start || !busy) begin
				if (stim_plan.size() == 0) begin
					start <= 1'b0;
					plan_drained <= 1'b1;
				end else begin
					next_step = stim_plan[0];
					case (next_step.kind)
						STEP_REQ: begin
							// Random gaps, except for a calm stretch in the middle.
							if ((n_taken < CALM_FIRST || n_taken >= CALM_LAST) &&
								$urandom_range(99) < 36) begin
								start <= 1'b0;
							end else begin
								start <= 1'b1;
								opcode <= next_step.op;
								lookup_word <= next_step.word;
								write_table <= next_step.tbl;
								write_addr <= next_step.waddr;
								write_data <= next_step.wdata;
								stim_plan.delete(0);
							end
						end
						STEP_PAUSE: begin
							// Hold off until every result is back and the pipeline is empty.
							start <= 1'b0;
							if (n_checked == n_predicted) begin
								if (settle_count >= SETTLE_CYCLES) begin
									settle_count <= 0;
									stim_plan.delete(0);
								end else begin
									settle_count <= settle_count + 1;
								end
							end else begin
								settle_count <= 0;
							end
						end
						default: begin
							start <= 1'b0;
							psel <= 1'b1;
							penable <= 1'b0;
							pwrite <= 1'b1;
							paddr <= {next_step.reg_idx, 2'b00};
							pwdata <= next_step.reg_val;
							bus_phase <= BUS_SETUP;
							stim_plan.delete(0);
						end
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result with the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("Mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && result_valid) begin
			if (lookup_expect.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("Result %h %h %h %h with no lookup pending",
						result_0, result_1, result_2, result_3);
			end else begin
				want = lookup_expect[0];
				lookup_expect.delete(0);
				check_field("result_0", want.r0, result_0);
				check_field("result_1", want.r1, result_1);
				check_field("result_2", want.r2, result_2);
				check_field("result_3", want.r3, result_3);
				n_checked <= n_checked + 1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus plan and end of run
	// ------------------------------------------------------------------
	initial begin
		logic [2:0]  mode;
		logic [31:0] word;
		int          phase_len;
		int          roll;

		// Directed part: field extremes, every mode, bank extremes.
		plan_write(2'd0, 10'd0, 32'h0000_0000);
		plan_write(2'd1, 10'd0, 32'hffff_ffff);
		plan_write(2'd2, 10'd0, 32'ha5a5_a5a5);
		plan_write(2'd3, 10'd0, 32'h5a5a_5a5a);
		plan_phase(MODE_NIB4, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'h0000_0000);
		plan_phase(MODE_NIB6, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'h0000_0000);
		plan_phase(MODE_BYTE, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'hffff_ffff);
		plan_phase(MODE_FOLD, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'hffff_ffff);
		plan_phase(MODE_WORDS, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'h0000_0000);
		// Nine-bit select with bit 8 clear, then set.
		plan_phase(MODE_SEL9, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'h0000_0000);
		plan_lookup(32'h0000_ff00);
		// Undefined modes read address zero whatever the banks say.
		plan_phase(MODE_ZERO6, 2'd0, 2'd0, 2'd0, 2'd0);
		plan_lookup(32'hffff_ffff);
		plan_phase(MODE_ZERO7, 2'd3, 2'd3, 2'd3, 2'd3);
		plan_lookup(32'h0000_0000);
		plan_write(2'd3, 10'd1023, 32'hffff_ffff);
		plan_phase(MODE_WORDS, 2'd3, 2'd3, 2'd3, 2'd3);
		plan_lookup(32'hffff_ffff);

		// Random phases, each under its own register settings.
		while (n_planned_items < ITEM_TARGET) begin
			if ($urandom_range(9) == 0)
				mode = $urandom_range(1) ? MODE_ZERO7 : MODE_ZERO6;
			else
				mode = 3'($urandom_range(5));
			plan_phase(mode, 2'($urandom_range(3)), 2'($urandom_range(3)),
				2'($urandom_range(3)), 2'($urandom_range(3)));
			phase_len = $urandom_range(150, 40);
			for (int k = 0; k < phase_len && n_planned_items < ITEM_TARGET; k++) begin
				roll = $urandom_range(99);
				if (roll < 60) begin
					plan_lookup($urandom);
				end else if (roll < 80) begin
					plan_write(2'($urandom_range(3)), 10'($urandom_range(1023)), $urandom);
				end else if (roll < 98) begin
					// Overwrite some of the entries a word hits, then look it up at once.
					word = $urandom;
					for (int t = 0; t < 4; t++)
						if ($urandom_range(1))
							plan_write(2'(t), index_for(word, gen_mode, gen_bank[t], t), $urandom);
					plan_lookup(word);
				end else begin
					plan_pause();
				end
			end
		end
		plan_pause();

		wait (plan_drained);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && lookup_expect.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
